>>> rtl/boxds_pkg.sv
`default_nettype none
package boxds_pkg;

  localparam int LINE_W = 4096;
  localparam int IDX_W  = $clog2(LINE_W);
  localparam int DIM_W  = 13;
  localparam int EDGE_W = 14;
  localparam int REM_W  = 14;
  localparam int SUM_W  = 40;
  localparam int ASUM_W = 32;
  localparam int CNT_W  = 25;
  localparam int PIX_W  = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_SRC_W   = 3'd0;
  localparam logic [2:0] REG_SRC_H   = 3'd1;
  localparam logic [2:0] REG_TGT_W   = 3'd2;
  localparam logic [2:0] REG_TGT_H   = 3'd3;
  localparam logic [2:0] REG_A_MODE  = 3'd4;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef struct packed {
    logic [SUM_W-1:0]  r;
    logic [SUM_W-1:0]  g;
    logic [SUM_W-1:0]  b;
    logic [ASUM_W-1:0] a;
    logic [CNT_W-1:0]  n;
  } acc_t;

  localparam int WORD_W = $bits(acc_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_EMIT,
    ST_DIV,
    ST_PUSH
  } ctl_state_t;

  typedef struct packed {
    logic [EDGE_W-1:0]       edge_pos;
    logic signed [REM_W-1:0] rem;
  } edge_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(LINE_W)) res = DIM_W'(LINE_W);
    return res;
  endfunction

  // start + q, plus one when the running remainder goes positive
  function automatic edge_t next_edge(input logic [EDGE_W-1:0] start,
                                      input logic [DIM_W-1:0] q,
                                      input logic [DIM_W-1:0] r,
                                      input logic [DIM_W-1:0] dst,
                                      input logic signed [REM_W-1:0] rem);
    edge_t res;
    logic signed [REM_W-1:0] s;
    s = rem + $signed({1'b0, r});
    res.edge_pos = start + EDGE_W'(q);
    res.rem = s;
    if (s > 0) begin
      res.edge_pos = res.edge_pos + EDGE_W'(1);
      res.rem = s - $signed({1'b0, dst});
    end
    return res;
  endfunction

  function automatic logic signed [REM_W-1:0] neg_half(input logic [DIM_W-1:0] d);
    return -$signed({2'b00, d[DIM_W-1:1]});
  endfunction

endpackage
`default_nettype wire

>>> rtl/boxds_ram.sv
`default_nettype none
module boxds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/boxds_div13.sv
`default_nettype none
module boxds_div13 (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [boxds_pkg::DIM_W-1:0]   num,
  input  wire logic [boxds_pkg::DIM_W-1:0]   den,
  output logic      [boxds_pkg::DIM_W-1:0]   quo,
  output logic      [boxds_pkg::DIM_W-1:0]   rem,
  output logic                               busy
);
  import boxds_pkg::*;

  logic [DIM_W-1:0] den_q;
  logic [3:0]       step;
  logic [DIM_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[DIM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 4'(DIM_W);
    end else if (busy) begin
      step <= step - 4'd1;
      if (step == 4'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[DIM_W-2:0], ge};
      rem <= ge ? DIM_W'(trial - {1'b0, den_q}) : DIM_W'(trial);
    end
  end
endmodule
`default_nettype wire

>>> rtl/boxds_avgdiv.sv
`default_nettype none
module boxds_avgdiv (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [boxds_pkg::SUM_W-1:0]   num,
  input  wire logic [boxds_pkg::ASUM_W-1:0]  den,
  output logic      [boxds_pkg::PIX_W-1:0]   quo,
  output logic                               done
);
  import boxds_pkg::*;

  localparam int SH_W = ASUM_W + PIX_W - 1;

  logic [SUM_W-1:0]  rem;
  logic [SH_W-1:0]   dsh;
  logic [ASUM_W-1:0] den_q;
  logic [3:0]        step;
  logic              sat;
  logic              ge;

  // quotient above 255 saturates
  assign sat = {{(ASUM_W+PIX_W-SUM_W){1'b0}}, rem} >= {den_q, {PIX_W{1'b0}}};
  assign ge  = {{(SH_W+1-SUM_W){1'b0}}, rem} >= {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= 4'(PIX_W + 1);
      end else if (step == 4'(PIX_W + 1)) begin
        if (sat) begin
          step <= '0;
          done <= 1'b1;
        end else begin
          step <= step - 4'd1;
        end
      end else if (step != '0) begin
        step <= step - 4'd1;
        if (step == 4'd1) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_q <= den;
      dsh   <= {den, {(PIX_W-1){1'b0}}};
      quo   <= '0;
    end else if (step == 4'(PIX_W + 1)) begin
      if (sat) quo <= '1;
    end else if (step != '0) begin
      quo <= {quo[PIX_W-2:0], ge};
      if (ge) rem <= rem - SUM_W'(dsh);
      dsh <= dsh >> 1;
    end
  end
endmodule
`default_nettype wire

>>> rtl/box_average_image_downscaler_top.sv
// Box-average image downscaler.
// Source pixels enter on the in_* channel (in_valid / in_stall) in raster
// order; averaged destination pixels leave on the out_* channel
// (out_valid / out_stall), frame_last marking the final one of the image.
// Geometry and alpha mode are set over the APB port; any write of a valid
// register restarts the frame.
// Per-column sums live in one 4096-entry RAM, read-modify-written per pixel.
// A pixel that closes a block has each channel (3 channels opaque, 4 in
// alpha mode) divided in turn by the shared 8-step saturating divider,
// except in alpha mode when its alpha sum is zero.
// After reset and after each register write a clearing pass zeroes all
// 4096 entries of the sum RAM; in_stall is high during it.
// The result sits in an output register: while out_stall holds it, the
// block keeps taking pixels until it has another result to hand over.
`default_nettype none
module box_average_image_downscaler_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [boxds_pkg::PIX_W-1:0]  in_red,
  input  wire logic [boxds_pkg::PIX_W-1:0]  in_green,
  input  wire logic [boxds_pkg::PIX_W-1:0]  in_blue,
  input  wire logic [boxds_pkg::PIX_W-1:0]  in_alpha,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [boxds_pkg::PIX_W-1:0]  out_red,
  output logic      [boxds_pkg::PIX_W-1:0]  out_green,
  output logic      [boxds_pkg::PIX_W-1:0]  out_blue,
  output logic      [boxds_pkg::PIX_W-1:0]  out_alpha,
  output logic                              frame_last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [boxds_pkg::ADDR_W-1:0] paddr,
  input  wire logic [boxds_pkg::DATA_W-1:0] pwdata,
  output logic      [boxds_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);
  import boxds_pkg::*;

  ctl_state_t state, state_next;

  logic [DIM_W-1:0] src_w, src_h, tgt_w, tgt_h;
  logic             alpha_mode;
  logic [DIM_W-1:0] sw, sh, tw, th, tw_c, th_c;
  logic [2:0]       reg_idx;
  logic             cfg_wr;
  logic             dim_start;

  logic [DIM_W-1:0] qw, rw, qh, rh;
  logic             divw_busy, divh_busy;

  logic [IDX_W-1:0] col_pos, row_pos, blk_col;
  logic [EDGE_W-1:0] right_edge, bottom_edge;
  logic signed [REM_W-1:0] col_rem, row_rem;
  logic [DIM_W-1:0] clr_cnt;

  logic             accept;
  logic [DIM_W-1:0] x1, y1;
  logic             col_end, row_end, last_px;
  edge_t            col_nx, row_nx, row0, col0;

  logic [PIX_W-1:0] pr, pg, pb, pa;
  logic             emit_q, last_q;
  logic [IDX_W-1:0] idx_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  acc_t             ram_wdata, ram_rdata, acc_new, emit_acc;
  logic [SUM_W-1:0] add_r, add_g, add_b;

  logic [1:0]        ch, ch_last, start_ch;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_num;
  logic [ASUM_W-1:0] div_den, cnt_den;
  logic [PIX_W-1:0]  div_q;
  logic [PIX_W-1:0]  res_r, res_g, res_b, res_a;
  logic              out_free;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (reg_idx == REG_SRC_W || reg_idx == REG_SRC_H ||
                    reg_idx == REG_TGT_W || reg_idx == REG_TGT_H ||
                    reg_idx == REG_A_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w      <= DIM_W'(1);
      src_h      <= DIM_W'(1);
      tgt_w      <= DIM_W'(1);
      tgt_h      <= DIM_W'(1);
      alpha_mode <= 1'b0;
      dim_start  <= 1'b1;
    end else begin
      dim_start <= cfg_wr;
      if (cfg_wr) begin
        case (reg_idx)
          REG_SRC_W:  src_w      <= pwdata[DIM_W-1:0];
          REG_SRC_H:  src_h      <= pwdata[DIM_W-1:0];
          REG_TGT_W:  tgt_w      <= pwdata[DIM_W-1:0];
          REG_TGT_H:  tgt_h      <= pwdata[DIM_W-1:0];
          REG_A_MODE: alpha_mode <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_W:  prdata = DATA_W'(src_w);
      REG_SRC_H:  prdata = DATA_W'(src_h);
      REG_TGT_W:  prdata = DATA_W'(tgt_w);
      REG_TGT_H:  prdata = DATA_W'(tgt_h);
      REG_A_MODE: prdata = DATA_W'(alpha_mode);
      default:    prdata = '0;
    endcase
  end

  assign sw   = clamp_dim(src_w);
  assign sh   = clamp_dim(src_h);
  assign tw_c = clamp_dim(tgt_w);
  assign th_c = clamp_dim(tgt_h);
  assign tw   = (tw_c > sw) ? sw : tw_c;
  assign th   = (th_c > sh) ? sh : th_c;

  boxds_div13 u_divw (
    .clk(clk), .rst(rst), .start(dim_start), .num(sw), .den(tw),
    .quo(qw), .rem(rw), .busy(divw_busy)
  );

  boxds_div13 u_divh (
    .clk(clk), .rst(rst), .start(dim_start), .num(sh), .den(th),
    .quo(qh), .rem(rh), .busy(divh_busy)
  );

  // pixel position and block edges
  assign accept  = (state == ST_IDLE) && in_valid;
  assign in_stall = (state != ST_IDLE);
  assign x1      = DIM_W'(col_pos) + DIM_W'(1);
  assign y1      = DIM_W'(row_pos) + DIM_W'(1);
  assign col_end = (EDGE_W'(x1) >= right_edge) || (x1 == sw);
  assign row_end = (EDGE_W'(y1) >= bottom_edge) || (y1 == sh);
  assign last_px = (x1 == sw) && (y1 == sh);
  assign col_nx  = next_edge(EDGE_W'(x1), qw, rw, tw, col_rem);
  assign row_nx  = next_edge(EDGE_W'(y1), qh, rh, th, row_rem);
  assign col0    = next_edge('0, qw, rw, tw, neg_half(tw));
  assign row0    = next_edge('0, qh, rh, th, neg_half(th));

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || (state == ST_CLEAR && state_next == ST_IDLE) ||
        (accept && x1 == sw && y1 == sh)) begin
      col_pos     <= '0;
      row_pos     <= '0;
      blk_col     <= '0;
      right_edge  <= col0.edge_pos;
      col_rem     <= col0.rem;
      bottom_edge <= row0.edge_pos;
      row_rem     <= row0.rem;
    end else if (accept) begin
      if (x1 < sw) begin
        col_pos <= x1[IDX_W-1:0];
        if (col_end) begin
          if (DIM_W'(blk_col) + DIM_W'(1) < tw) blk_col <= blk_col + IDX_W'(1);
          right_edge <= col_nx.edge_pos;
          col_rem    <= col_nx.rem;
        end
      end else begin
        if (row_end) begin
          bottom_edge <= row_nx.edge_pos;
          row_rem     <= row_nx.rem;
        end
        row_pos    <= y1[IDX_W-1:0];
        col_pos    <= '0;
        blk_col    <= '0;
        right_edge <= col0.edge_pos;
        col_rem    <= col0.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pr     <= in_red;
      pg     <= in_green;
      pb     <= in_blue;
      pa     <= in_alpha;
      emit_q <= col_end && row_end;
      last_q <= last_px;
      idx_q  <= blk_col;
    end
  end

  // sum RAM read-modify-write
  assign add_r = alpha_mode ? SUM_W'(16'(pa) * 16'(pr)) : SUM_W'(pr);
  assign add_g = alpha_mode ? SUM_W'(16'(pa) * 16'(pg)) : SUM_W'(pg);
  assign add_b = alpha_mode ? SUM_W'(16'(pa) * 16'(pb)) : SUM_W'(pb);

  always_comb begin
    acc_new.r = ram_rdata.r + add_r;
    acc_new.g = ram_rdata.g + add_g;
    acc_new.b = ram_rdata.b + add_b;
    acc_new.a = alpha_mode ? ram_rdata.a + ASUM_W'(pa) : ram_rdata.a;
    acc_new.n = ram_rdata.n + CNT_W'(1);
  end

  assign ram_we    = (state == ST_CLEAR) || (state == ST_UPD);
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt[IDX_W-1:0] : idx_q;
  assign ram_wdata = (state == ST_CLEAR || emit_q) ? '0 : acc_new;

  boxds_ram #(.WIDTH(WORD_W), .DEPTH(LINE_W)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(blk_col), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (state == ST_UPD) emit_acc <= acc_new;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) clr_cnt <= '0;
    else if (state == ST_CLEAR && clr_cnt != DIM_W'(LINE_W - 1)) clr_cnt <= clr_cnt + DIM_W'(1);
  end

  // divider sequencing over channels
  assign ch_last   = alpha_mode ? CH_ALPHA : CH_BLUE;
  assign start_ch  = (state == ST_EMIT) ? CH_RED : ch + 2'd1;
  assign div_start = (state == ST_EMIT && !(alpha_mode && emit_acc.a == '0)) ||
                     (state == ST_DIV && div_done && ch != ch_last);
  assign cnt_den   = (emit_acc.n == '0) ? ASUM_W'(1) : ASUM_W'(emit_acc.n);

  always_comb begin
    case (start_ch)
      CH_RED:   div_num = emit_acc.r;
      CH_GREEN: div_num = emit_acc.g;
      CH_BLUE:  div_num = emit_acc.b;
      default:  div_num = SUM_W'(emit_acc.a);
    endcase
    div_den = (alpha_mode && start_ch != CH_ALPHA) ? emit_acc.a : cnt_den;
  end

  boxds_avgdiv u_avgdiv (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_q), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      ch    <= CH_RED;
      res_r <= '0;
      res_g <= '0;
      res_b <= '0;
      res_a <= '0;
    end else if (state == ST_DIV && div_done) begin
      case (ch)
        CH_RED:   res_r <= div_q;
        CH_GREEN: res_g <= div_q;
        CH_BLUE:  res_b <= div_q;
        default:  res_a <= div_q;
      endcase
      ch <= ch + 2'd1;
    end
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && out_free) begin
      out_red    <= res_r;
      out_green  <= res_g;
      out_blue   <= res_b;
      out_alpha  <= res_a;
      frame_last <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == DIM_W'(LINE_W - 1) && !divw_busy && !divh_busy && !dim_start)
          state_next = ST_IDLE;
      end
      ST_IDLE: if (accept) state_next = ST_UPD;
      ST_UPD:  state_next = emit_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: state_next = div_start ? ST_DIV : ST_PUSH;
      ST_DIV:  if (div_done && ch == ch_last) state_next = ST_PUSH;
      ST_PUSH: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
    if (cfg_wr) state_next = ST_CLEAR;
  end
endmodule
`default_nettype wire

>>> rtl/boxds_checker.sv
`default_nettype none
module boxds_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [boxds_pkg::PIX_W-1:0]  out_red,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [boxds_pkg::ADDR_W-1:0] paddr,
  input wire logic                         pready
);
  import boxds_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red))
    else $error("stalled transfer dropped or changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("reset did not start clearing pass");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_SRC_W |=> in_stall)
    else $error("register write did not restart frame");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
endmodule

bind box_average_image_downscaler_top boxds_checker u_boxds_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_red(out_red), .psel(psel), .penable(penable),
  .pwrite(pwrite), .paddr(paddr), .pready(pready)
);
`default_nettype wire
